@@ rtl/maca_pkg.sv @@
// maca_pkg: types, constants and codes shared by the MAC controller modules.
// No dependencies.
package maca_pkg;
   localparam int QueueDepth = 16;
   localparam int QueueAw    = $clog2(QueueDepth);
   localparam int CountW     = QueueAw + 1;
   localparam int RandBits   = 16;
   localparam int TimerW     = 24;
   localparam logic [7:0] Broadcast = 8'd255;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_CONTEND = 3'd1,
      MODE_WFCTS   = 3'd2,
      MODE_WFDATA  = 3'd3,
      MODE_QUIET   = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_ENQ   = 2'd1,
      ACT_FRAME = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      FRM_RTS  = 2'd0,
      FRM_CTS  = 2'd1,
      FRM_DATA = 2'd2
   } frame_type;

   typedef enum logic [1:0] {
      SEND_NONE = 2'd0,
      SEND_RTS  = 2'd1,
      SEND_CTS  = 2'd2,
      SEND_DATA = 2'd3
   } send_type;

   typedef enum logic [2:0] {
      REG_OWN_ADDR = 3'd0,
      REG_PROP     = 3'd1,
      REG_CTS      = 3'd2,
      REG_DATA     = 3'd3,
      REG_MIN_WIN  = 3'd4,
      REG_MAX_WIN  = 3'd5
   } reg_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_MULA = 2'd1,
      ST_EXEC = 2'd2,
      ST_OUT  = 2'd3
   } ctl_state_type;

   typedef struct packed {
      logic       load;
      logic       mul_a;
      logic       exec;
   } cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic [1:0] ftype;
      logic [7:0] src;
      logic [7:0] dst;
      logic       busy;
      logic [15:0] rnd;
   } req_word_type;

   typedef struct packed {
      logic [1:0] send_kind;
      logic [7:0] send_dest;
      logic       deliver;
      logic [7:0] deliver_src;
      logic       dropped;
      logic [2:0] mac_status;
      logic [4:0] queue_count;
   } rsp_word_type;
endpackage

@@ rtl/maca_req_if.sv @@
// maca_req_if, maca_rsp_if: valid/ready channels of the MAC controller.
// No dependencies.
interface maca_req_if (input logic clock);
   logic valid;
   logic ready;
   logic [1:0] action;
   logic [1:0] frame_type;
   logic [7:0] frame_src;
   logic [7:0] frame_addr;
   logic       phy_busy;
   logic [15:0] rand_req;
   modport source (output valid, action, frame_type, frame_src, frame_addr, phy_busy,
                   rand_req, input ready);
   modport sink (input valid, action, frame_type, frame_src, frame_addr, phy_busy,
                 rand_req, output ready);
endinterface

interface maca_rsp_if (input logic clock);
   logic valid;
   logic ready;
   logic [1:0] send_kind;
   logic [7:0] send_dest;
   logic       deliver;
   logic [7:0] deliver_src;
   logic       dropped;
   logic [2:0] mac_status;
   logic [4:0] queue_count;
   modport source (output valid, send_kind, send_dest, deliver, deliver_src, dropped,
                   mac_status, queue_count, input ready);
   modport sink (input valid, send_kind, send_dest, deliver, deliver_src, dropped,
                 mac_status, queue_count, output ready);
endinterface

@@ rtl/maca_mac_controller.sv @@
// maca_mac_controller: top level of the MACA RTS/CTS medium access controller.
// Depends on maca_pkg, maca_req_if/maca_rsp_if, maca_ctrl and maca_datapath.
//
//  channel  | dir | handshake        | word
//  req      | in  | valid/ready      | action, frame header, phy_busy, rand_req
//  rsp      | out | valid/ready      | send, deliver, dropped, status, count
//  csr      | in  | write enable     | index 0..5, 16-bit data
//
// Each word passes through these steps in order: accept with span products, rand
// products, event update, result. The split backoff multiply gives the separate
// rand-products step.
// Reset is synchronous; all timers, queue and mode clear, registers take defaults.
// A stalled result holds the block; the next word is taken once it is read.
module maca_mac_controller (
   input logic               clock,
   input logic               reset,
   maca_req_if.sink          req,
   maca_rsp_if.source        rsp,
   input logic               csr_write,
   input logic [2:0]         csr_index,
   input logic [15:0]        csr_data
);
   maca_pkg::cmd_type      cmd;
   maca_pkg::req_word_type req_word;
   maca_pkg::rsp_word_type rsp_word;

   assign req_word.action = req.action;
   assign req_word.ftype  = req.frame_type;
   assign req_word.src    = req.frame_src;
   assign req_word.dst    = req.frame_addr;
   assign req_word.busy   = req.phy_busy;
   assign req_word.rnd    = req.rand_req;

   maca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd)
   );

   maca_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_word  (req_word),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_word  (rsp_word)
   );

   assign rsp.send_kind   = rsp_word.send_kind;
   assign rsp.send_dest   = rsp_word.send_dest;
   assign rsp.deliver     = rsp_word.deliver;
   assign rsp.deliver_src = rsp_word.deliver_src;
   assign rsp.dropped     = rsp_word.dropped;
   assign rsp.mac_status  = rsp_word.mac_status;
   assign rsp.queue_count = rsp_word.queue_count;
endmodule

@@ rtl/maca_ctrl.sv @@
// maca_ctrl: sequencer for one word: load, backoff product, execute, output.
// Depends on maca_pkg.
module maca_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output maca_pkg::cmd_type     cmd
);
   maca_pkg::ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= maca_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         maca_pkg::ST_IDLE: begin
            if (req_valid) state_in = maca_pkg::ST_MULA;
         end
         maca_pkg::ST_MULA: state_in = maca_pkg::ST_EXEC;
         maca_pkg::ST_EXEC: state_in = maca_pkg::ST_OUT;
         maca_pkg::ST_OUT: begin
            if (rsp_ready) state_in = maca_pkg::ST_IDLE;
         end
         default: state_in = maca_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd = '0;
      case (state_ff)
         maca_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         maca_pkg::ST_MULA: cmd.mul_a = 1'b1;
         maca_pkg::ST_EXEC: cmd.exec = 1'b1;
         maca_pkg::ST_OUT: rsp_valid = 1'b1;
         default: ;
      endcase
   end
endmodule

@@ rtl/maca_datapath.sv @@
// maca_datapath: registers, FIFO, timers, backoff multiplier and event logic.
// Depends on maca_pkg.
module maca_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  maca_pkg::cmd_type      cmd,
   input  maca_pkg::req_word_type req_word,
   input  logic                   csr_write,
   input  logic [2:0]             csr_index,
   input  logic [15:0]            csr_data,
   output maca_pkg::rsp_word_type rsp_word
);
   localparam int TW = maca_pkg::TimerW;
   localparam int AW = maca_pkg::QueueAw;
   localparam int CW = maca_pkg::CountW;
   localparam int RB = maca_pkg::RandBits;

   logic [7:0]  own_ff;
   logic [15:0] prop_ff, cts_ff, data_ff;
   logic [6:0]  minw_ff, maxw_ff;

   maca_pkg::req_word_type req_ff;
   maca_pkg::mode_type mode_ff, mode_in;
   logic [7:0]    fifo_ff [maca_pkg::QueueDepth];
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [6:0]    beb_ff, beb_in;
   logic [TW-1:0] bo_left_ff, bo_left_in, q_left_ff, q_left_in, w_left_ff, w_left_in;
   logic          bo_on_ff, bo_on_in, q_on_ff, q_on_in, w_on_ff, w_on_in;
   logic [23:0]   span_ff, span2_ff;
   logic [39:0]   prod_pre_ff, prod_post_ff;
   maca_pkg::rsp_word_type rsp_ff, rsp_in;

   logic          fifo_we;
   logic [AW-1:0] fifo_wa;
   logic [RB-1:0] rnd;
   logic [16:0]   pc_sum;
   logic [6:0]    beb_dbl;
   logic [6:0]    win_alt;
   logic [7:0]    dbl_full;
   logic [TW-1:0] bo_pre, bo_post, wait_cts, wait_data, quiet_cts, quiet_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ff  <= 8'd1;
         prop_ff <= 16'd300;
         cts_ff  <= 16'd100;
         data_ff <= 16'd200;
         minw_ff <= 7'd1;
         maxw_ff <= 7'd10;
      end else if (csr_write) begin
         case (csr_index)
            maca_pkg::REG_OWN_ADDR: own_ff  <= csr_data[7:0];
            maca_pkg::REG_PROP:     prop_ff <= csr_data;
            maca_pkg::REG_CTS:      cts_ff  <= csr_data;
            maca_pkg::REG_DATA:     data_ff <= csr_data;
            maca_pkg::REG_MIN_WIN:  minw_ff <= csr_data[6:0];
            maca_pkg::REG_MAX_WIN:  maxw_ff <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   assign rnd     = req_ff.rnd[RB-1:0];
   assign pc_sum  = {1'b0, prop_ff} + {1'b0, cts_ff};
   assign dbl_full = {beb_ff, 1'b0};
   assign beb_dbl = (dbl_full < {1'b0, maxw_ff}) ? dbl_full[6:0] : maxw_ff;
   assign win_alt = (req_word.action == maca_pkg::ACT_TICK) ? beb_dbl : minw_ff;
   assign wait_cts  = TW'({prop_ff, 1'b0}) + TW'(cts_ff);
   assign wait_data = TW'({prop_ff, 1'b0}) + TW'(data_ff);
   assign quiet_cts  = wait_cts;
   assign quiet_data = wait_data;
   assign bo_pre  = prod_pre_ff[RB +: TW];
   assign bo_post = prod_post_ff[RB +: TW];

   // span with current window, and with doubled (tick) or minimum (enqueue, frame) window
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff   <= req_word;
         span_ff  <= {17'd0, beb_ff} * {7'd0, pc_sum};
         span2_ff <= {17'd0, win_alt} * {7'd0, pc_sum};
      end
      if (cmd.mul_a) begin
         prod_pre_ff  <= {16'd0, span_ff} * {24'd0, rnd};
         prod_post_ff <= {16'd0, span2_ff} * {24'd0, rnd};
      end
   end

   always_ff @(posedge clock) begin
      if (fifo_we) fifo_ff[fifo_wa] <= req_ff.dst;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= maca_pkg::MODE_IDLE;
         head_ff <= '0;
         count_ff <= '0;
         beb_ff <= 7'd1;
         bo_left_ff <= '0; q_left_ff <= '0; w_left_ff <= '0;
         bo_on_ff <= 1'b0; q_on_ff <= 1'b0; w_on_ff <= 1'b0;
      end else if (cmd.exec) begin
         mode_ff <= mode_in;
         head_ff <= head_in;
         count_ff <= count_in;
         beb_ff <= beb_in;
         bo_left_ff <= bo_left_in; q_left_ff <= q_left_in; w_left_ff <= w_left_in;
         bo_on_ff <= bo_on_in; q_on_ff <= q_on_in; w_on_ff <= w_on_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) rsp_ff <= rsp_in;
   end
   assign rsp_word = rsp_ff;

   always_comb begin
      logic from_own, to_me, doubled;
      mode_in = mode_ff; head_in = head_ff; count_in = count_ff; beb_in = beb_ff;
      bo_left_in = bo_left_ff; q_left_in = q_left_ff; w_left_in = w_left_ff;
      bo_on_in = bo_on_ff; q_on_in = q_on_ff; w_on_in = w_on_ff;
      rsp_in = '0;
      fifo_we = 1'b0;
      fifo_wa = head_ff + count_ff[AW-1:0];
      from_own = (req_ff.src == own_ff);
      to_me = (req_ff.dst == own_ff);
      doubled = 1'b0;
      case (req_ff.action)
         maca_pkg::ACT_TICK: begin
            if (q_on_in && q_left_in != '0) q_left_in = q_left_in - 1'b1;
            if (w_on_in && w_left_in != '0) w_left_in = w_left_in - 1'b1;
            if (bo_on_in && bo_left_in != '0) bo_left_in = bo_left_in - 1'b1;
            if (q_on_in && q_left_in == '0) begin
               q_on_in = 1'b0;
               mode_in = maca_pkg::MODE_IDLE;
               bo_left_in = bo_pre; bo_on_in = 1'b1;
            end
            if (w_on_in && w_left_in == '0) begin
               w_on_in = 1'b0;
               beb_in = beb_dbl;
               doubled = 1'b1;
               mode_in = maca_pkg::MODE_IDLE;
               bo_left_in = bo_post; bo_on_in = 1'b1;
            end
            if (bo_on_in && bo_left_in == '0) begin
               bo_on_in = 1'b0;
               if (count_in != '0) begin
                  if (!req_ff.busy) begin
                     rsp_in.send_kind = maca_pkg::SEND_RTS;
                     rsp_in.send_dest = fifo_ff[head_ff];
                     mode_in = maca_pkg::MODE_WFCTS;
                     w_left_in = wait_cts; w_on_in = 1'b1;
                  end else begin
                     mode_in = maca_pkg::MODE_CONTEND;
                     bo_left_in = doubled ? bo_post : bo_pre; bo_on_in = 1'b1;
                  end
               end
            end
         end
         maca_pkg::ACT_ENQ: begin
            if (count_ff >= CW'(maca_pkg::QueueDepth)) begin
               rsp_in.dropped = 1'b1;
            end else begin
               fifo_we = 1'b1;
               count_in = count_ff + 1'b1;
               if (mode_ff == maca_pkg::MODE_IDLE) begin
                  mode_in = maca_pkg::MODE_CONTEND;
                  if (!bo_on_ff || count_ff == '0) begin
                     bo_left_in = bo_pre; bo_on_in = 1'b1;
                  end
               end
            end
         end
         maca_pkg::ACT_FRAME: begin
            if (!from_own) begin
               case (req_ff.ftype)
                  maca_pkg::FRM_RTS: begin
                     if (mode_ff == maca_pkg::MODE_QUIET) begin
                        if (!to_me && !(q_on_ff && q_left_ff > quiet_cts)) begin
                           q_left_in = quiet_cts;
                        end
                        if (!to_me) q_on_in = 1'b1;
                     end else if (mode_ff == maca_pkg::MODE_IDLE ||
                                  mode_ff == maca_pkg::MODE_CONTEND) begin
                        if (to_me) begin
                           if (!req_ff.busy) begin
                              rsp_in.send_kind = maca_pkg::SEND_CTS;
                              rsp_in.send_dest = req_ff.src;
                              bo_on_in = 1'b0; bo_left_in = '0;
                              mode_in = maca_pkg::MODE_WFDATA;
                              w_left_in = wait_data; w_on_in = 1'b1;
                           end
                        end else begin
                           bo_on_in = 1'b0; bo_left_in = '0;
                           q_left_in = quiet_cts; q_on_in = 1'b1;
                           mode_in = maca_pkg::MODE_QUIET;
                        end
                     end
                  end
                  maca_pkg::FRM_CTS: begin
                     if (mode_ff == maca_pkg::MODE_WFCTS && to_me) begin
                        w_on_in = 1'b0; w_left_in = '0;
                        if (count_ff != '0) begin
                           beb_in = minw_ff;
                           if (!req_ff.busy) begin
                              rsp_in.send_kind = maca_pkg::SEND_DATA;
                              rsp_in.send_dest = fifo_ff[head_ff];
                              head_in = head_ff + 1'b1;
                              count_in = count_ff - 1'b1;
                           end
                        end
                        mode_in = maca_pkg::MODE_IDLE;
                        // window falls back to minimum only with a packet queued
                        bo_left_in = (count_ff != '0) ? bo_post : bo_pre;
                        bo_on_in = 1'b1;
                     end else if (!to_me) begin
                        if (mode_ff == maca_pkg::MODE_QUIET) begin
                           if (!(q_on_ff && q_left_ff > quiet_data)) q_left_in = quiet_data;
                           q_on_in = 1'b1;
                        end else if (mode_ff != maca_pkg::MODE_WFDATA) begin
                           bo_on_in = 1'b0; bo_left_in = '0;
                           w_on_in = 1'b0; w_left_in = '0;
                           q_left_in = quiet_data; q_on_in = 1'b1;
                           mode_in = maca_pkg::MODE_QUIET;
                        end
                     end
                  end
                  maca_pkg::FRM_DATA: begin
                     if (mode_ff == maca_pkg::MODE_WFDATA &&
                         (to_me || req_ff.dst == maca_pkg::Broadcast)) begin
                        mode_in = maca_pkg::MODE_IDLE;
                        w_on_in = 1'b0; w_left_in = '0;
                        rsp_in.deliver = 1'b1;
                        rsp_in.deliver_src = req_ff.src;
                     end
                  end
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
      rsp_in.mac_status = mode_in;
      rsp_in.queue_count = count_in;
   end
endmodule

@@ rtl/maca_checker.sv @@
// maca_checker: port-level checks on the MAC controller, bound to the top level.
// Depends on maca_pkg.
module maca_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  send_kind,
   input logic        deliver,
   input logic [7:0]  deliver_src,
   input logic        dropped,
   input logic [2:0]  mac_status,
   input logic [4:0]  queue_count
);
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("req taken while result pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(mac_status))
      else $error("result dropped");
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> queue_count <= 5'(maca_pkg::QueueDepth)) else $error("count range");
   a_deliver: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && deliver |-> send_kind == maca_pkg::SEND_NONE && !dropped &&
      mac_status == maca_pkg::MODE_IDLE) else $error("deliver mix");
   a_nodeliver: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !deliver |-> deliver_src == 8'd0) else $error("stray src");
endmodule

bind maca_mac_controller maca_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req.valid),
   .req_ready   (req.ready),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .send_kind   (rsp.send_kind),
   .deliver     (rsp.deliver),
   .deliver_src (rsp.deliver_src),
   .dropped     (rsp.dropped),
   .mac_status  (rsp.mac_status),
   .queue_count (rsp.queue_count)
);

@@ tb/sv/maca_mac_controller_tb.sv @@
// maca_mac_controller_tb: self-checking bench for the MACA MAC controller.
// Drives request words, predicts each response word and checks it in order.
// Depends on maca_pkg, maca_req_if/maca_rsp_if and maca_mac_controller.
module maca_mac_controller_tb;
   import maca_pkg::*;

   class mac_scoreboard;
      logic [7:0]  own_addr;
      logic [15:0] prop_t, cts_t, data_t;
      logic [6:0]  win_min, win_max;
      mode_type    mode;
      logic [7:0]  dests [QueueDepth];
      int unsigned head, count, beb;
      int unsigned boff_left, quiet_left, wait_left;
      bit          boff_on, quiet_on, wait_on;
      logic [1:0]  s_kind;
      logic [7:0]  s_dest;
      rsp_word_type pending[$];
      int          errors;

      function void clear();
         own_addr = 1; prop_t = 300; cts_t = 100; data_t = 200;
         win_min = 1; win_max = 10;
         mode = MODE_IDLE; head = 0; count = 0; beb = 1;
         boff_left = 0; quiet_left = 0; wait_left = 0;
         boff_on = 0; quiet_on = 0; wait_on = 0;
         errors = 0;
         pending.delete();
      endfunction

      function void write_reg(reg_type idx, logic [15:0] v);
         case (idx)
            REG_OWN_ADDR: own_addr = v[7:0];
            REG_PROP:     prop_t = v;
            REG_CTS:      cts_t = v;
            REG_DATA:     data_t = v;
            REG_MIN_WIN:  win_min = v[6:0];
            REG_MAX_WIN:  win_max = v[6:0];
            default: ;
         endcase
      endfunction

      function void arm_backoff(logic [15:0] r);
         longint unsigned span;
         span = longint'(beb) * (longint'(prop_t) + longint'(cts_t));
         boff_left = ((longint'(r) * span) >> RandBits) & 24'hFFFFFF;
         boff_on = 1;
      endfunction

      function void silence(int unsigned period, bit extend);
         if (!(extend && quiet_on && quiet_left > period)) quiet_left = period & 24'hFFFFFF;
         quiet_on = 1;
         mode = MODE_QUIET;
      endfunction

      function void backoff_done(bit busy, logic [15:0] r);
         if (count == 0) return;
         mode = MODE_CONTEND;
         if (!busy) begin
            s_kind = SEND_RTS; s_dest = dests[head];
            mode = MODE_WFCTS;
            wait_left = (2 * prop_t + cts_t) & 24'hFFFFFF;
            wait_on = 1;
         end else arm_backoff(r);
      endfunction

      function void note_word(req_word_type w);
         rsp_word_type e;
         int unsigned d;
         bit drop, dlv;
         logic [7:0] dsrc;
         drop = 0; dlv = 0; dsrc = 0; s_kind = SEND_NONE; s_dest = 0;
         if (w.action == ACT_TICK) begin
            if (quiet_on && quiet_left > 0) quiet_left--;
            if (wait_on && wait_left > 0) wait_left--;
            if (boff_on && boff_left > 0) boff_left--;
            if (quiet_on && quiet_left == 0) begin
               quiet_on = 0; mode = MODE_IDLE; arm_backoff(w.rnd);
            end
            if (wait_on && wait_left == 0) begin
               d = 2 * beb;
               wait_on = 0;
               beb = d < win_max ? d : win_max;
               mode = MODE_IDLE; arm_backoff(w.rnd);
            end
            if (boff_on && boff_left == 0) begin
               boff_on = 0; backoff_done(w.busy, w.rnd);
            end
         end else if (w.action == ACT_ENQ) begin
            if (count >= QueueDepth) drop = 1;
            else begin
               dests[(head + count) % QueueDepth] = w.dst;
               count++;
               if (mode == MODE_IDLE) begin
                  mode = MODE_CONTEND;
                  if (!boff_on || count == 1) arm_backoff(w.rnd);
               end
            end
         end else if (w.action == ACT_FRAME && w.src != own_addr) begin
            if (w.ftype == FRM_RTS) begin
               if (mode == MODE_QUIET) begin
                  if (w.dst != own_addr) silence(2 * prop_t + cts_t, 1);
               end else if (mode == MODE_IDLE || mode == MODE_CONTEND) begin
                  if (w.dst == own_addr) begin
                     if (!w.busy) begin
                        s_kind = SEND_CTS; s_dest = w.src;
                        boff_on = 0; boff_left = 0;
                        mode = MODE_WFDATA;
                        wait_left = (2 * prop_t + data_t) & 24'hFFFFFF;
                        wait_on = 1;
                     end
                  end else begin
                     boff_on = 0; boff_left = 0;
                     silence(2 * prop_t + cts_t, 0);
                  end
               end
            end else if (w.ftype == FRM_CTS) begin
               if (mode == MODE_WFCTS && w.dst == own_addr) begin
                  wait_on = 0; wait_left = 0;
                  if (count > 0) begin
                     beb = win_min;
                     if (!w.busy) begin
                        s_kind = SEND_DATA; s_dest = dests[head];
                        head = (head + 1) % QueueDepth;
                        count--;
                     end
                  end
                  mode = MODE_IDLE;
                  arm_backoff(w.rnd);
               end else if (w.dst != own_addr) begin
                  if (mode == MODE_QUIET) silence(2 * prop_t + data_t, 1);
                  else if (mode != MODE_WFDATA) begin
                     boff_on = 0; boff_left = 0; wait_on = 0; wait_left = 0;
                     silence(2 * prop_t + data_t, 0);
                  end
               end
            end else if (w.ftype == FRM_DATA && mode == MODE_WFDATA &&
                         (w.dst == own_addr || w.dst == Broadcast)) begin
               mode = MODE_IDLE; wait_on = 0; wait_left = 0;
               dlv = 1; dsrc = w.src;
            end
         end
         e.send_kind = s_kind; e.send_dest = s_dest;
         e.deliver = dlv; e.deliver_src = dsrc; e.dropped = drop;
         e.mac_status = mode; e.queue_count = count[4:0];
         pending.push_back(e);
      endfunction

      function void check_word(rsp_word_type got);
         rsp_word_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response word %h", $time, got);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.send_kind !== e.send_kind || got.send_dest !== e.send_dest ||
             got.deliver !== e.deliver || got.deliver_src !== e.deliver_src ||
             got.dropped !== e.dropped || got.mac_status !== e.mac_status ||
             got.queue_count !== e.queue_count) begin
            $display("%0t: expected kind %0d dest %0d dlv %0d src %0d drop %0d mode %0d cnt %0d",
                     $time, e.send_kind, e.send_dest, e.deliver, e.deliver_src, e.dropped,
                     e.mac_status, e.queue_count);
            $display("%0t: actual   kind %0d dest %0d dlv %0d src %0d drop %0d mode %0d cnt %0d",
                     $time, got.send_kind, got.send_dest, got.deliver, got.deliver_src,
                     got.dropped, got.mac_status, got.queue_count);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_write = 0;
   logic [2:0]  csr_index = 0;
   logic [15:0] csr_data = 0;
   bit          feeding_done = 0;
   mac_scoreboard sb;

   maca_req_if req (clock);
   maca_rsp_if rsp (clock);

   maca_mac_controller dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   initial begin
      req.valid = 0; req.action = 0; req.frame_type = 0; req.frame_src = 0;
      req.frame_addr = 0; req.phy_busy = 0; req.rand_req = 0;
      rsp.ready = 0;
   end

   // response side: random stalls, check on every accepted word
   initial begin
      int gap;
      rsp_word_type w;
      @(posedge clock);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
         if (gap != 0) begin
            rsp.ready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp.ready <= 1;
         do @(posedge clock); while (!(rsp.valid && rsp.ready));
         w = '{rsp.send_kind, rsp.send_dest, rsp.deliver, rsp.deliver_src, rsp.dropped,
               rsp.mac_status, rsp.queue_count};
         sb.check_word(w);
      end
   end

   task automatic write_csr(reg_type idx, logic [15:0] v);
      csr_write <= 1; csr_index <= idx; csr_data <= v;
      @(posedge clock);
      csr_write <= 0;
      sb.write_reg(idx, v);
      @(posedge clock);
   endtask

   // valid stays high after acceptance until the next word or a drain
   task automatic send_word(req_word_type w, bit no_gap = 0);
      int gap;
      gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
         req.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1;
      req.action <= w.action; req.frame_type <= w.ftype; req.frame_src <= w.src;
      req.frame_addr <= w.dst; req.phy_busy <= w.busy; req.rand_req <= w.rnd;
      do @(posedge clock); while (!(req.valid && req.ready));
      sb.note_word(w);
   endtask

   task automatic drain();
      req.valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   function automatic req_word_type make_word(action_type a, frame_type f, logic [7:0] s,
                                              logic [7:0] d, bit b, logic [15:0] r);
      req_word_type w;
      w.action = a; w.ftype = f; w.src = s; w.dst = d; w.busy = b; w.rnd = r;
      return w;
   endfunction

   // mostly protocol-shaped traffic around own address, some pure noise
   function automatic req_word_type rand_word();
      req_word_type w;
      int pick;
      w = req_word_type'(37'({$urandom, $urandom}));
      pick = $urandom_range(0, 99);
      w.busy = ($urandom_range(0, 7) == 0);
      if (pick < 45) w.action = ACT_TICK;
      else if (pick < 60) w.action = ACT_ENQ;
      else if (pick < 95) begin
         w.action = ACT_FRAME;
         w.ftype = frame_type'($urandom_range(0, 2));
         case ($urandom_range(0, 3))
            0, 1: w.dst = sb.own_addr;
            2: w.dst = Broadcast;
            default: ;
         endcase
         if ($urandom_range(0, 15) == 0) w.src = sb.own_addr;
      end
      if ($urandom_range(0, 3) != 0) w.rnd = 16'($urandom_range(0, 255));
      return w;
   endfunction

   initial begin
      req_word_type w;
      sb = new();
      sb.clear();
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: short timers so handshakes complete
      write_csr(REG_PROP, 2); write_csr(REG_CTS, 1); write_csr(REG_DATA, 1);
      send_word(make_word(ACT_ENQ, FRM_RTS, 0, 8'h55, 0, 16'hFFFF));
      send_word(make_word(ACT_TICK, FRM_RTS, 0, 0, 1, 16'h0000));
      repeat (6) send_word(make_word(ACT_TICK, FRM_RTS, 0, 0, 0, 16'h0000));
      send_word(make_word(ACT_ENQ, FRM_RTS, 0, 8'hAA, 0, 0));
      repeat (4) send_word(make_word(ACT_TICK, FRM_RTS, 0, 0, 0, 0));
      send_word(make_word(ACT_FRAME, FRM_CTS, 8'h09, 8'd1, 0, 16'h8000));
      send_word(make_word(ACT_FRAME, FRM_RTS, 8'hFF, 8'd1, 0, 0));
      send_word(make_word(ACT_FRAME, FRM_DATA, 8'hFF, Broadcast, 0, 0));
      send_word(make_word(ACT_FRAME, FRM_RTS, 8'd1, 8'd0, 0, 0));
      send_word(make_word(ACT_FRAME, FRM_RTS, 8'd7, 8'd0, 0, 0));
      send_word(make_word(ACT_FRAME, FRM_CTS, 8'd7, 8'd0, 0, 0));
      send_word(make_word(ACT_FRAME, frame_type'(2'd3), 8'd7, 8'd1, 0, 0));
      send_word(make_word(action_type'(2'd3), FRM_RTS, 8'd7, 8'd1, 1, 16'hFFFF));
      repeat (17) send_word(make_word(ACT_ENQ, FRM_RTS, 0, 8'h00, 0, 16'hFFFF), 1);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               write_csr(REG_OWN_ADDR, 0); write_csr(REG_PROP, 0);
               write_csr(REG_CTS, 0); write_csr(REG_DATA, 0);
               write_csr(REG_MIN_WIN, 1); write_csr(REG_MAX_WIN, 127);
            end
            1: begin
               write_csr(REG_OWN_ADDR, 254); write_csr(REG_PROP, 3);
               write_csr(REG_CTS, 2); write_csr(REG_DATA, 4);
               write_csr(REG_MIN_WIN, 127); write_csr(REG_MAX_WIN, 1);
            end
            2: begin
               write_csr(REG_OWN_ADDR, 16'($urandom_range(0, 254))); write_csr(REG_PROP, 1);
               write_csr(REG_CTS, 5); write_csr(REG_DATA, 2);
               write_csr(REG_MIN_WIN, 2); write_csr(REG_MAX_WIN, 8);
            end
            default: begin
               // extreme spans exercise the multiply; ticks carry zero rand
               write_csr(REG_OWN_ADDR, 1); write_csr(REG_PROP, 16'hFFFF);
               write_csr(REG_CTS, 16'hFFFF); write_csr(REG_DATA, 16'hFFFF);
               write_csr(REG_MIN_WIN, 0); write_csr(REG_MAX_WIN, 0);
            end
         endcase
         repeat (phase == 3 ? 100 : 500) begin
            w = rand_word();
            if (phase == 3 && w.action == ACT_TICK) w.rnd = 0;
            send_word(w);
         end
         drain();
      end
      feeding_done = 1;
   end

   initial begin
      wait (feeding_done);
      if (sb.errors == 0)
         $display("[maca_mac_controller] OK");
      else
         $display("[maca_mac_controller] ERROR");
      $finish;
   end

   initial begin
      #20000000;
      $display("[maca_mac_controller] ERROR");
      $finish;
   end
endmodule

@@ files.f @@
rtl/maca_pkg.sv
rtl/maca_req_if.sv
rtl/maca_ctrl.sv
rtl/maca_datapath.sv
rtl/maca_mac_controller.sv
rtl/maca_checker.sv
tb/sv/maca_mac_controller_tb.sv
